### design/arp_request_responder_top_defines.svh
// assertion helpers for the arp responder
`ifndef ARP_REQUEST_RESPONDER_TOP_DEFINES_SVH
`define ARP_REQUEST_RESPONDER_TOP_DEFINES_SVH

// checked outside reset
`define ARP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define ARP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### design/arp_resp_pkg.sv
package arp_resp_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 64;

   localparam logic [15:0] ETH_TYPE_ARP   = 16'h0806;
   localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
   localparam logic [15:0] ARP_OP_REPLY   = 16'd2;

   localparam logic KIND_PACKET = 1'b0;
   localparam logic KIND_ADD    = 1'b1;

   typedef enum logic [1:0] {
      STATUS_REPLY   = 2'd0,
      STATUS_DROP    = 2'd1,
      STATUS_WRITTEN = 2'd2,
      STATUS_FULL    = 2'd3
   } status_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] eth_type;
      logic [47:0] eth_dst;
      logic [47:0] eth_src;
      logic [15:0] arp_op;
      logic [47:0] sender_mac;
      logic [31:0] sender_ip;
      logic [47:0] target_mac;
      logic [31:0] target_ip;
      logic [31:0] entry_ip;
      logic [47:0] entry_mac;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [47:0] out_eth_dst;
      logic [47:0] out_eth_src;
      logic [15:0] out_arp_op;
      logic [47:0] out_sender_mac;
      logic [31:0] out_sender_ip;
      logic [47:0] out_target_mac;
      logic [31:0] out_target_ip;
   } rsp_type;

   // search token handed from cell to cell
   typedef struct packed {
      logic        active;
      logic        hit;
      logic        free;
      logic [47:0] mac;
   } link_type;

   // table write broadcast to all cells
   typedef struct packed {
      logic        en;
      logic [31:0] ip;
      logic [47:0] mac;
   } wr_type;

endpackage

### design/arp_resp_cell.sv
module arp_resp_cell #(
   parameter int IDX_W      = 6,
   parameter int CELL_INDEX = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [31:0]                 key,
   input  arp_resp_pkg::wr_type        wr,
   input  logic [IDX_W-1:0]            wr_idx,
   input  arp_resp_pkg::link_type      link_in,
   input  logic [IDX_W-1:0]            hit_idx_in,
   input  logic [IDX_W-1:0]            free_idx_in,
   output arp_resp_pkg::link_type      link_out,
   output logic [IDX_W-1:0]            hit_idx_out,
   output logic [IDX_W-1:0]            free_idx_out
);

   localparam logic [IDX_W-1:0] SELF = IDX_W'(CELL_INDEX);

   logic                   valid_ff;
   logic [31:0]            ip_ff;
   logic [47:0]            mac_ff;
   arp_resp_pkg::link_type link_ff, link_in_nxt;
   logic [IDX_W-1:0]       hit_idx_ff, hit_idx_in_nxt;
   logic [IDX_W-1:0]       free_idx_ff, free_idx_in_nxt;
   logic                   match;
   logic                   wr_here;

   assign match   = valid_ff && (ip_ff == key);
   assign wr_here = wr.en && (wr_idx == SELF);

   always_comb begin
      link_in_nxt     = link_in;
      hit_idx_in_nxt  = hit_idx_in;
      free_idx_in_nxt = free_idx_in;
      // lowest matching slot wins
      if (!link_in.hit && match) begin
         link_in_nxt.hit = 1'b1;
         link_in_nxt.mac = mac_ff;
         hit_idx_in_nxt  = SELF;
      end
      // lowest free slot
      if (!link_in.free && !valid_ff) begin
         link_in_nxt.free = 1'b1;
         free_idx_in_nxt  = SELF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= 1'b0;
         link_ff.active <= 1'b0;
      end else begin
         if (wr_here) begin
            valid_ff <= 1'b1;
         end
         link_ff.active <= link_in_nxt.active;
      end
      if (wr_here) begin
         ip_ff  <= wr.ip;
         mac_ff <= wr.mac;
      end
      link_ff.hit  <= link_in_nxt.hit;
      link_ff.free <= link_in_nxt.free;
      link_ff.mac  <= link_in_nxt.mac;
      hit_idx_ff   <= hit_idx_in_nxt;
      free_idx_ff  <= free_idx_in_nxt;
   end

   assign link_out     = link_ff;
   assign hit_idx_out  = hit_idx_ff;
   assign free_idx_out = free_idx_ff;

endmodule

### design/arp_request_responder_top.sv
// channel   ports                     direction  handshake
// request   start, busy, req_data     in         accepted when start && !busy
// response  rsp_valid, rsp_data       out        one-cycle strobe, no back-pressure
//
// a new request is accepted only once the search token has left the last cell and busy is low again
// the search token walks the row of table cells one cell per cycle
// the response strobe comes in the first cycle in which busy is low again
// synchronous active-high reset empties the table
// the receiver cannot stall, so every response is taken when shown

`include "arp_request_responder_top_defines.svh"

module arp_request_responder_top #(
   parameter int TABLE_ENTRIES = arp_resp_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  arp_resp_pkg::req_type req_data,
   output logic                  rsp_valid,
   output arp_resp_pkg::rsp_type rsp_data
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   arp_resp_pkg::link_type links     [TABLE_ENTRIES+1];
   logic [IDX_W-1:0]       hit_idxs  [TABLE_ENTRIES+1];
   logic [IDX_W-1:0]       free_idxs [TABLE_ENTRIES+1];

   logic                  busy_ff, busy_in;
   logic                  launch_ff, launch_in;
   arp_resp_pkg::req_type req_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   arp_resp_pkg::rsp_type rsp_ff, rsp_in;
   arp_resp_pkg::wr_type  wr;
   logic [IDX_W-1:0]      wr_idx;
   logic [31:0]           key;
   logic                  accept;
   logic                  done;
   logic                  is_request;
   arp_resp_pkg::link_type tail;

   assign accept = start && !busy_ff;
   assign key    = (req_ff.kind == arp_resp_pkg::KIND_ADD) ? req_ff.entry_ip
                                                          : req_ff.target_ip;

   assign links[0]     = '{active: launch_ff, hit: 1'b0, free: 1'b0, mac: 48'd0};
   assign hit_idxs[0]  = '0;
   assign free_idxs[0] = '0;

   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      arp_resp_cell #(
         .IDX_W      (IDX_W),
         .CELL_INDEX (g)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .key          (key),
         .wr           (wr),
         .wr_idx       (wr_idx),
         .link_in      (links[g]),
         .hit_idx_in   (hit_idxs[g]),
         .free_idx_in  (free_idxs[g]),
         .link_out     (links[g+1]),
         .hit_idx_out  (hit_idxs[g+1]),
         .free_idx_out (free_idxs[g+1])
      );
   end

   assign tail       = links[TABLE_ENTRIES];
   assign done       = tail.active;
   assign is_request = (req_ff.eth_type == arp_resp_pkg::ETH_TYPE_ARP) &&
                       (req_ff.arp_op == arp_resp_pkg::ARP_OP_REQUEST);

   always_comb begin
      wr           = '{en: 1'b0, ip: req_ff.entry_ip, mac: req_ff.entry_mac};
      wr_idx       = tail.hit ? hit_idxs[TABLE_ENTRIES] : free_idxs[TABLE_ENTRIES];
      rsp_in       = '0;
      rsp_in.status = arp_resp_pkg::STATUS_DROP;
      rsp_valid_in = done;
      launch_in    = accept;
      busy_in      = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end
      if (done) begin
         busy_in = 1'b0;
         if (req_ff.kind == arp_resp_pkg::KIND_ADD) begin
            if (tail.hit || tail.free) begin
               wr.en         = 1'b1;
               rsp_in.status = arp_resp_pkg::STATUS_WRITTEN;
            end else begin
               rsp_in.status = arp_resp_pkg::STATUS_FULL;
            end
         end else if (is_request && tail.hit) begin
            rsp_in.status         = arp_resp_pkg::STATUS_REPLY;
            rsp_in.out_eth_dst    = req_ff.eth_src;
            rsp_in.out_eth_src    = tail.mac;
            rsp_in.out_arp_op     = arp_resp_pkg::ARP_OP_REPLY;
            rsp_in.out_sender_mac = tail.mac;
            rsp_in.out_sender_ip  = req_ff.target_ip;
            rsp_in.out_target_mac = req_ff.sender_mac;
            rsp_in.out_target_ip  = req_ff.sender_ip;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         req_ff <= req_data;
      end
      if (done) begin
         rsp_ff <= rsp_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ARP_ASSERT(a_accept_busy, (start && !busy) |=> busy, "busy not raised after acceptance")
   `ARP_ASSERT(a_rsp_idle, rsp_valid |-> !busy, "response shown while still busy")
   `ARP_ASSERT(a_rsp_single, rsp_valid |=> !rsp_valid, "response strobe longer than one cycle")
   `ARP_ASSERT_ALWAYS(a_token_busy, done |-> busy_ff, "search token outside a transaction")

endmodule
